>>> hdl/sph_poly6_density_accumulator_defines.svh
// assertion macros used by the top-level accumulator
`ifndef SPH_POLY6_DENSITY_ACCUMULATOR_DEFINES_SVH
`define SPH_POLY6_DENSITY_ACCUMULATOR_DEFINES_SVH

// implication in the same cycle, ignored while in reset
`define SPH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, checked during reset as well
`define SPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/sph_pkg.sv
`timescale 1ns / 1ps
package sph_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int POS_W  = 32;
  localparam int MAG_W  = 32;
  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W  = 40;
  localparam int ADDR_W = 4;
  localparam int IDX_W  = 2;

  localparam logic [DATA_W-1:0] RADIUS_SQ_RST   = 32'd65536;
  localparam logic [DATA_W-1:0] KERNEL_COEF_RST = 32'd102676;
  localparam logic [DATA_W-1:0] MIN_DENSITY_RST = 32'd0;

  localparam logic [IDX_W-1:0] REG_RADIUS_SQ   = 2'd0;
  localparam logic [IDX_W-1:0] REG_KERNEL_COEF = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_DENSITY = 2'd2;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic             valid;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] radius_sq;
    logic [DATA_W-1:0] kernel_coef;
    logic [DATA_W-1:0] min_density;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_AX0,
    B_AX1,
    B_AX2,
    B_DIFF,
    B_L2,
    B_L3,
    B_W,
    B_ACC,
    B_FIN
  } back_state_t;

endpackage

>>> hdl/sph_front.sv
`timescale 1ns / 1ps
module sph_front (
  input  logic signed [sph_pkg::POS_W-1:0] in_self_x,
  input  logic signed [sph_pkg::POS_W-1:0] in_self_y,
  input  logic signed [sph_pkg::POS_W-1:0] in_self_z,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_x,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_y,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_z,
  input  logic                             in_nbr_valid,
  input  logic                             in_last_neighbor,
  input  logic                             push,
  output logic                             full,
  input  logic                             q_full,
  output logic                             q_push,
  output sph_pkg::item_t                   q_item
);
  import sph_pkg::*;

  // exact axis difference, magnitude fits in 32 bits
  function automatic logic [MAG_W-1:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic        [POS_W:0] m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (~d + 1'b1) : d;
    return m[MAG_W-1:0];
  endfunction

  always_comb begin
    q_item.mag_x = abs_diff(in_self_x, in_nbr_x);
    q_item.mag_y = abs_diff(in_self_y, in_nbr_y);
    q_item.mag_z = abs_diff(in_self_z, in_nbr_z);
    q_item.valid = in_nbr_valid;
    q_item.last  = in_last_neighbor;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

endmodule

>>> hdl/sph_queue.sv
`timescale 1ns / 1ps
module sph_queue #(
  parameter int DEPTH = sph_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  sph_pkg::item_t wr_item,
  output logic           full,
  input  logic           rd_en,
  output sph_pkg::item_t rd_item,
  output logic           empty
);
  import sph_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hdl/sph_back.sv
`timescale 1ns / 1ps
module sph_back #(
  parameter int FRAC_BITS = sph_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sph_pkg::cfg_t               cfg,
  input  sph_pkg::item_t              q_item,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic                        pop,
  output logic                        empty,
  output logic [sph_pkg::DATA_W-1:0]  out_density,
  output logic                        out_was_clamped
);
  import sph_pkg::*;

  localparam int D2_W = PROD_W - FRAC_BITS + 2;
  localparam logic [D2_W-1:0] D2_MAX32 = D2_W'(33'h0FFFFFFFF);
  localparam logic [PROD_W-1:0] SH_MAX32 = PROD_W'(33'h0FFFFFFFF);

  back_state_t        state_r, state_nxt;
  item_t              cur_r, cur_nxt;
  logic [D2_W-1:0]    d2_r, d2_nxt;
  logic [MAG_W-1:0]   l_r, l_nxt;
  logic [DATA_W-1:0]  t_r, t_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  dens_r, dens_nxt;
  logic               clamp_r, clamp_nxt;

  logic [MAG_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  prod, sh;
  logic [DATA_W-1:0]  sh_sat, d2_sat, sum_sat;
  logic [SUM_W:0]     sum_add;
  logic               slot_free;

  // one shared multiplier, operands picked by the sequencer step
  always_comb begin
    case (state_r)
      B_AX0:   begin mul_a = cur_r.mag_x; mul_b = cur_r.mag_x; end
      B_AX1:   begin mul_a = cur_r.mag_y; mul_b = cur_r.mag_y; end
      B_AX2:   begin mul_a = cur_r.mag_z; mul_b = cur_r.mag_z; end
      B_L2:    begin mul_a = l_r;         mul_b = l_r;         end
      B_L3:    begin mul_a = t_r;         mul_b = l_r;         end
      B_W:     begin mul_a = cfg.kernel_coef; mul_b = t_r;     end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sh        = prod >> FRAC_BITS;
  assign sh_sat    = (sh > SH_MAX32) ? '1 : sh[DATA_W-1:0];
  assign d2_sat    = (d2_r > D2_MAX32) ? '1 : d2_r[DATA_W-1:0];
  assign sum_add   = {1'b0, sum_r} + (SUM_W + 1)'(t_r);
  assign sum_sat   = (sum_r[SUM_W-1:DATA_W] != '0) ? '1 : sum_r[DATA_W-1:0];
  assign slot_free = !out_valid_r || pop;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    d2_nxt        = d2_r;
    l_nxt         = l_r;
    t_nxt         = t_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !pop;
    dens_nxt      = dens_r;
    clamp_nxt     = clamp_r;
    q_pop         = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cur_nxt   = q_item;
          state_nxt = q_item.valid ? B_AX0 : B_FIN;
        end
      end
      B_AX0: begin
        d2_nxt    = D2_W'(sh);
        state_nxt = B_AX1;
      end
      B_AX1: begin
        d2_nxt    = d2_r + D2_W'(sh);
        state_nxt = B_AX2;
      end
      B_AX2: begin
        d2_nxt    = d2_r + D2_W'(sh);
        state_nxt = B_DIFF;
      end
      B_DIFF: begin
        if (d2_sat < cfg.radius_sq) begin
          l_nxt     = cfg.radius_sq - d2_sat;
          state_nxt = B_L2;
        end else begin
          state_nxt = B_FIN;
        end
      end
      B_L2: begin
        t_nxt     = sh_sat;
        state_nxt = B_L3;
      end
      B_L3: begin
        t_nxt     = sh_sat;
        state_nxt = B_W;
      end
      B_W: begin
        t_nxt     = sh_sat;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        sum_nxt   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        state_nxt = B_FIN;
      end
      B_FIN: begin
        if (!cur_r.last) begin
          state_nxt = B_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (sum_sat < cfg.min_density) begin
            dens_nxt  = cfg.min_density;
            clamp_nxt = 1'b1;
          end else begin
            dens_nxt  = sum_sat;
            clamp_nxt = 1'b0;
          end
          sum_nxt   = '0;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    d2_r    <= d2_nxt;
    l_r     <= l_nxt;
    t_r     <= t_nxt;
    dens_r  <= dens_nxt;
    clamp_r <= clamp_nxt;
  end

  assign empty           = !out_valid_r;
  assign out_density     = dens_r;
  assign out_was_clamped = clamp_r;

endmodule

>>> hdl/sph_poly6_density_accumulator.sv
// sequencer: a pair inside the radius steps IDLE, AX0-AX2, DIFF, L2, L3, W, ACC, FIN; one
// outside goes from DIFF to FIN, an invalid pair from IDLE to FIN; the result is registered in
// FIN once the result slot is free; one pair at a time, the single shared 32x32 multiplier
// stepping three axis squares and three kernel products; the input queue takes pairs ahead
// reset: synchronous, active low; clears queue, sum, result slot and loads register defaults
`timescale 1ns / 1ps
`include "sph_poly6_density_accumulator_defines.svh"
module sph_poly6_density_accumulator #(
  parameter int FRAC_BITS   = sph_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = sph_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic signed [sph_pkg::POS_W-1:0] in_self_x,
  input  logic signed [sph_pkg::POS_W-1:0] in_self_y,
  input  logic signed [sph_pkg::POS_W-1:0] in_self_z,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_x,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_y,
  input  logic signed [sph_pkg::POS_W-1:0] in_nbr_z,
  input  logic                             in_nbr_valid,
  input  logic                             in_last_neighbor,
  input  logic                             push,
  output logic                             full,
  output logic [sph_pkg::DATA_W-1:0]       out_density,
  output logic                             out_was_clamped,
  output logic                             empty,
  input  logic                             pop,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sph_pkg::ADDR_W-1:0]       paddr,
  input  logic [sph_pkg::DATA_W-1:0]       pwdata,
  output logic [sph_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sph_pkg::*;

  cfg_t              cfg_r;
  logic [IDX_W-1:0]  reg_idx;
  logic              wr_en;
  item_t             f_item, q_item;
  logic              q_push, q_pop, q_full, q_empty;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius_sq   <= RADIUS_SQ_RST;
      cfg_r.kernel_coef <= KERNEL_COEF_RST;
      cfg_r.min_density <= MIN_DENSITY_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RADIUS_SQ:   cfg_r.radius_sq   <= pwdata;
        REG_KERNEL_COEF: cfg_r.kernel_coef <= pwdata;
        REG_MIN_DENSITY: cfg_r.min_density <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS_SQ:   prdata = cfg_r.radius_sq;
      REG_KERNEL_COEF: prdata = cfg_r.kernel_coef;
      REG_MIN_DENSITY: prdata = cfg_r.min_density;
      default:         prdata = '0;
    endcase
  end

  sph_front u_front (
    .in_self_x        (in_self_x),
    .in_self_y        (in_self_y),
    .in_self_z        (in_self_z),
    .in_nbr_x         (in_nbr_x),
    .in_nbr_y         (in_nbr_y),
    .in_nbr_z         (in_nbr_z),
    .in_nbr_valid     (in_nbr_valid),
    .in_last_neighbor (in_last_neighbor),
    .push             (push),
    .full             (full),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_item           (f_item)
  );

  sph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_item (f_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  sph_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_item          (q_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_density     (out_density),
    .out_was_clamped (out_was_clamped)
  );

  `SPH_ASSERT_IMPL(a_queue_state, q_full, !q_empty, "queue reports full and empty at once")
  `SPH_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_empty, "sequencer took a pair from an empty queue")
  `SPH_ASSERT_NEXT(a_reset_empty, !rst_n, empty && !full, "result slot or queue busy after reset")

endmodule
